/* rtl/dsm_pkg.sv */
// Shared types and constants for the duplicate scan merger.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package dsm_pkg;

    localparam int          COUNT_W         = 8;
    localparam logic [7:0]  GROUP_COUNT_MAX = 8'd255;

    localparam int          DIV_STEPS       = 64;
    localparam int          STEP_W          = $clog2(DIV_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_ADD,
        S_DIV_OLD,
        S_WAIT_OLD,
        S_OPEN,
        S_DIV_NEW,
        S_WAIT_NEW
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic mul;
        logic add;
        logic open_grp;
        logic div_start;
        logic load_out;
        logic out_last;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic group_open;
        logic same_scan;
        logic in_last;
        logic div_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/dsm_divider.sv */
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// Depends on dsm_pkg for the step count.
`default_nettype none

module dsm_divider
    import dsm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_busy,
    output logic [31:0]      o_quotient
);

    logic              r_busy;
    logic [STEP_W-1:0] r_steps;
    logic [31:0]       r_rem;
    logic [63:0]       r_work;
    logic [31:0]       r_div;
    logic [32:0]       n_shift;
    logic              n_bit;
    logic [32:0]       n_diff;

    always_comb begin
        n_shift = {r_rem, r_work[63]};
        n_diff  = n_shift - {1'b0, r_div};
        n_bit   = (n_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_steps <= STEP_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_steps <= r_steps - STEP_W'(1);
            if (r_steps == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_work <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_bit ? n_diff[31:0] : n_shift[31:0];
            r_work <= {r_work[62:0], n_bit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_work[31:0];

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider not busy after start");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_start) |=> $stable(r_work))
        else $error("quotient changed while idle");

endmodule

`default_nettype wire

/* rtl/dsm_datapath.sv */
// Datapath: input latch, multiplier, group accumulators, output register.
// Depends on dsm_pkg and instantiates dsm_divider.
`default_nettype none

module dsm_datapath
    import dsm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    input  wire logic [31:0] i_scan_number,
    input  wire logic [31:0] i_retention_time,
    input  wire logic [31:0] i_mass_to_charge,
    input  wire logic [23:0] i_abundance,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_out_scan_number,
    output logic [31:0]      o_out_retention_time,
    output logic [31:0]      o_out_mass_to_charge,
    output logic [31:0]      o_out_abundance,
    output logic             o_out_last,
    output logic             o_group_overflow
);

    logic [31:0]        r_in_scan;
    logic [31:0]        r_in_time;
    logic [31:0]        r_in_mz;
    logic [23:0]        r_in_ab;
    logic               r_in_last;
    logic [55:0]        r_prod;

    logic               r_open;
    logic [31:0]        r_scan;
    logic [31:0]        r_time;
    logic [63:0]        r_wsum;
    logic [39:0]        r_psum;
    logic [31:0]        r_ab_sum;
    logic [COUNT_W-1:0] r_count;
    logic               r_ovf;

    logic               r_out_valid;
    logic [31:0]        r_out_scan;
    logic [31:0]        r_out_time;
    logic [31:0]        r_out_mz;
    logic [31:0]        r_out_ab;
    logic               r_out_last;
    logic               r_out_ovf;

    logic [63:0]        n_dividend;
    logic [31:0]        n_divisor;
    logic               div_busy;
    logic [31:0]        div_quot;
    logic               out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_scan <= i_scan_number;
            r_in_time <= i_retention_time;
            r_in_mz   <= i_mass_to_charge;
            r_in_ab   <= i_abundance;
            r_in_last <= i_is_last;
        end
        if (i_cmd.mul) begin
            r_prod <= {24'd0, r_in_mz} * {32'd0, r_in_ab};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_cmd.clear) begin
            r_open <= 1'b0;
        end else if (i_cmd.open_grp) begin
            r_open <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.open_grp) begin
            r_scan   <= r_in_scan;
            r_time   <= r_in_time;
            r_wsum   <= {8'd0, r_prod};
            r_psum   <= {8'd0, r_in_mz};
            r_ab_sum <= {8'd0, r_in_ab};
            r_count  <= COUNT_W'(1);
            r_ovf    <= 1'b0;
        end else if (i_cmd.add) begin
            if (r_count >= GROUP_COUNT_MAX) begin
                r_ovf <= 1'b1;
            end else begin
                r_wsum   <= r_wsum + {8'd0, r_prod};
                r_psum   <= r_psum + {8'd0, r_in_mz};
                r_ab_sum <= r_ab_sum + {8'd0, r_in_ab};
                r_count  <= r_count + COUNT_W'(1);
            end
        end
    end

    always_comb begin
        if (r_ab_sum != 32'd0) begin
            n_dividend = r_wsum;
            n_divisor  = r_ab_sum;
        end else begin
            n_dividend = {24'd0, r_psum};
            n_divisor  = {{(32 - COUNT_W){1'b0}}, r_count};
        end
    end

    dsm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quot)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_scan <= r_scan;
            r_out_time <= r_time;
            r_out_mz   <= div_quot;
            r_out_ab   <= r_ab_sum;
            r_out_last <= i_cmd.out_last;
            r_out_ovf  <= r_ovf;
        end
    end

    always_comb begin
        o_status.group_open = r_open;
        o_status.same_scan  = (r_in_scan == r_scan);
        o_status.in_last    = r_in_last;
        o_status.div_busy   = div_busy;
        o_status.out_free   = out_free;
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_scan_number    = r_out_scan;
    assign o_out_retention_time = r_out_time;
    assign o_out_mass_to_charge = r_out_mz;
    assign o_out_abundance      = r_out_ab;
    assign o_out_last           = r_out_last;
    assign o_group_overflow     = r_out_ovf;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall) && !div_busy)
        else $error("result loaded over a pending transaction or mid-division");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy && r_open)
        else $error("division started while busy or with no group");

endmodule

`default_nettype wire

/* rtl/dsm_ctrl.sv */
// Controller state machine: sequences latch, multiply, add, open, divide and emit steps.
// Depends on dsm_pkg for the state enum and the command and status structs.
`default_nettype none

module dsm_ctrl
    import dsm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.group_open && i_status.same_scan) begin
                    n_state = S_ADD;
                end else if (i_status.group_open) begin
                    n_state = S_DIV_OLD;
                end else begin
                    n_state = S_OPEN;
                end
            end
            S_ADD: begin
                n_state = i_status.in_last ? S_DIV_NEW : S_IDLE;
            end
            S_DIV_OLD: begin
                n_state = S_WAIT_OLD;
            end
            S_WAIT_OLD: begin
                if (!i_status.div_busy && i_status.out_free) begin
                    n_state = S_OPEN;
                end
            end
            S_OPEN: begin
                n_state = i_status.in_last ? S_DIV_NEW : S_IDLE;
            end
            S_DIV_NEW: begin
                n_state = S_WAIT_NEW;
            end
            S_WAIT_NEW: begin
                if (!i_status.div_busy && i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.latch_in = i_in_valid;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
            end
            S_DIV_OLD, S_DIV_NEW: begin
                o_cmd.div_start = 1'b1;
            end
            S_WAIT_OLD: begin
                o_cmd.load_out = !i_status.div_busy && i_status.out_free;
            end
            S_OPEN: begin
                o_cmd.open_grp = 1'b1;
            end
            S_WAIT_NEW: begin
                o_cmd.load_out = !i_status.div_busy && i_status.out_free;
                o_cmd.out_last = 1'b1;
                o_cmd.clear    = !i_status.div_busy && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_add_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.add |-> i_status.group_open && i_status.same_scan)
        else $error("add issued for a different scan");

endmodule

`default_nettype wire

/* rtl/duplicate_scan_merger_unit.sv */
// Top level of the duplicate scan merger: controller plus datapath.
// Depends on dsm_pkg, dsm_ctrl and dsm_datapath.
//
//   channel  direction  handshake                fields
//   input    in         i_in_valid / o_in_stall  scan, time, m/z, abundance, is_last
//   output   out        o_out_valid / i_out_stall scan, time, m/z, abundance, last, ovf
//
// An item that adds to the open group or opens a new one with none open is latched,
// multiplied, checked, then added or opened. Closing a group starts the 64-step shared divider
// and waits for it and a free output. A last item that closes a group gives two results.
// Synchronous active-low reset clears the state machine, group flag, divider and output valid.
// A stalled output holds its transaction; a due result waits until it drains.
`default_nettype none

module duplicate_scan_merger_unit
    import dsm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_scan_number,
    input  wire logic [31:0] i_retention_time,
    input  wire logic [31:0] i_mass_to_charge,
    input  wire logic [23:0] i_abundance,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_out_scan_number,
    output logic [31:0]      o_out_retention_time,
    output logic [31:0]      o_out_mass_to_charge,
    output logic [31:0]      o_out_abundance,
    output logic             o_out_last,
    output logic             o_group_overflow
);

    t_dp_cmd    cmd;
    t_dp_status status;

    dsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dsm_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_scan_number        (i_scan_number),
        .i_retention_time     (i_retention_time),
        .i_mass_to_charge     (i_mass_to_charge),
        .i_abundance          (i_abundance),
        .i_is_last            (i_is_last),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_out_scan_number    (o_out_scan_number),
        .o_out_retention_time (o_out_retention_time),
        .o_out_mass_to_charge (o_out_mass_to_charge),
        .o_out_abundance      (o_out_abundance),
        .o_out_last           (o_out_last),
        .o_group_overflow     (o_group_overflow)
    );

endmodule

`default_nettype wire
